// ===== design/owtm_pkg.sv =====
// owtm_pkg: shared types, phase codes, register indexes and the reading conversion
// for the single-wire thermometer master. No dependencies.
package owtm_pkg;

   // sequence phases (reset blocks use four consecutive codes each)
   localparam logic [4:0] PH_IDLE   = 5'd0;
   localparam logic [4:0] PH_R1_LOW = 5'd1;
   localparam logic [4:0] PH_R1_REL = 5'd2;
   localparam logic [4:0] PH_R1_PH  = 5'd3;
   localparam logic [4:0] PH_R1_PL  = 5'd4;
   localparam logic [4:0] PH_W_CC1  = 5'd5;
   localparam logic [4:0] PH_W_44   = 5'd6;
   localparam logic [4:0] PH_CONV   = 5'd7;
   localparam logic [4:0] PH_R2_LOW = 5'd8;
   localparam logic [4:0] PH_R2_REL = 5'd9;
   localparam logic [4:0] PH_R2_PH  = 5'd10;
   localparam logic [4:0] PH_R2_PL  = 5'd11;
   localparam logic [4:0] PH_W_CC2  = 5'd12;
   localparam logic [4:0] PH_W_BE   = 5'd13;
   localparam logic [4:0] PH_RD_LO  = 5'd14;
   localparam logic [4:0] PH_RD_HI  = 5'd15;

   // bus commands
   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_SP  = 8'hBE;

   // configuration register indexes
   localparam logic [2:0] REG_RESET_LOW   = 3'd0;
   localparam logic [2:0] REG_PRES_WAIT   = 3'd1;
   localparam logic [2:0] REG_PRES_TMO    = 3'd2;
   localparam logic [2:0] REG_LONG_SLOT   = 3'd3;
   localparam logic [2:0] REG_SHORT_SLOT  = 3'd4;
   localparam logic [2:0] REG_CONV_WAIT   = 3'd5;

   typedef struct packed {
      logic [11:0] reset_low;
      logic [7:0]  pres_wait;
      logic [7:0]  pres_tmo;
      logic [7:0]  long_slot;
      logic [7:0]  short_slot;
      logic [19:0] conv_wait;
   } cfg_type;

   typedef struct packed {
      logic [17:0] centi_degrees;
      logic        negative;
      logic        no_presence;
      logic        done_res;
      logic        busy_res;
      logic        drive_low;
   } result_type;

   // magnitude of a 16-bit two's complement reading times 6.25, truncated
   function automatic logic [17:0] raw_to_centi(input logic [15:0] raw);
      logic [15:0] mag;
      logic [19:0] prod;
      mag  = raw[15] ? (16'd0 - raw) : raw;
      prod = {mag, 4'b0000} + {1'b0, mag, 3'b000} + {4'b0000, mag};
      return prod[19:2];
   endfunction

endpackage

// ===== design/owtm_seq.sv =====
// owtm_seq: bus sequencer state and the per-tick next-state and result logic.
// Depends on owtm_pkg.
module owtm_seq
   import owtm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       start_req,
   input  logic       line_level,
   input  cfg_type    cfg,
   output result_type result
);

   logic [4:0]  phase_ff, phase_in;
   logic [19:0] tick_ff, tick_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  high_ff, high_in;
   logic        miss_ff, miss_in;
   logic [17:0] result_ff, result_in;

   logic [20:0] tick_inc;
   logic        in_r2;
   logic [4:0]  after_reset_ph;
   logic [7:0]  low_len;
   logic [8:0]  slot_total;
   logic [2:0]  bit_next;
   logic [7:0]  shift_rd;
   logic        drive;
   logic        done;

   assign tick_inc       = {1'b0, tick_ff} + 21'd1;
   assign in_r2          = (phase_ff >= PH_R2_LOW);
   assign after_reset_ph = in_r2 ? PH_W_CC2 : PH_W_CC1;
   assign low_len        = shift_ff[0] ? cfg.short_slot : cfg.long_slot;
   assign slot_total     = {1'b0, cfg.long_slot} + {1'b0, cfg.short_slot};
   assign bit_next       = bit_ff + 3'd1;
   assign shift_rd       = shift_ff | (8'(line_level) << bit_ff);

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      shift_in  = shift_ff;
      bit_in    = bit_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      miss_in   = miss_ff;
      result_in = result_ff;
      drive     = 1'b0;
      done      = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               phase_in = PH_R1_LOW;
               tick_in  = 20'd0;
               miss_in  = 1'b0;
            end
         end
         PH_R1_LOW, PH_R2_LOW: begin
            drive   = 1'b1;
            tick_in = tick_inc[19:0];
            if (tick_inc >= {9'd0, cfg.reset_low}) begin
               phase_in = in_r2 ? PH_R2_REL : PH_R1_REL;
               tick_in  = 20'd0;
            end
         end
         PH_R1_REL, PH_R2_REL: begin
            tick_in = tick_inc[19:0];
            if (tick_inc >= {13'd0, cfg.pres_wait}) begin
               phase_in = in_r2 ? PH_R2_PH : PH_R1_PH;
               tick_in  = 20'd0;
            end
         end
         PH_R1_PH, PH_R2_PH: begin
            if (!line_level) begin
               phase_in = in_r2 ? PH_R2_PL : PH_R1_PL;
               tick_in  = 20'd0;
            end else begin
               tick_in = tick_inc[19:0];
               if (tick_inc >= {13'd0, cfg.pres_tmo}) begin
                  miss_in  = 1'b1;
                  phase_in = after_reset_ph;
                  shift_in = CMD_SKIP_ROM;
                  bit_in   = 3'd0;
                  tick_in  = 20'd0;
               end
            end
         end
         PH_R1_PL, PH_R2_PL: begin
            if (line_level) begin
               phase_in = after_reset_ph;
               shift_in = CMD_SKIP_ROM;
               bit_in   = 3'd0;
               tick_in  = 20'd0;
            end else begin
               tick_in = tick_inc[19:0];
               if (tick_inc >= {13'd0, cfg.pres_tmo}) begin
                  miss_in  = 1'b1;
                  phase_in = after_reset_ph;
                  shift_in = CMD_SKIP_ROM;
                  bit_in   = 3'd0;
                  tick_in  = 20'd0;
               end
            end
         end
         PH_W_CC1, PH_W_44, PH_W_CC2, PH_W_BE: begin
            drive   = (tick_ff < {12'd0, low_len});
            tick_in = tick_inc[19:0];
            if (tick_inc >= {12'd0, slot_total}) begin
               tick_in  = 20'd0;
               shift_in = {1'b0, shift_ff[7:1]};
               bit_in   = bit_next;
               if (bit_next == 3'd0) begin
                  priority if (phase_ff == PH_W_CC1) begin
                     phase_in = PH_W_44;
                     shift_in = CMD_CONVERT;
                  end else if (phase_ff == PH_W_44) begin
                     phase_in = PH_CONV;
                  end else if (phase_ff == PH_W_CC2) begin
                     phase_in = PH_W_BE;
                     shift_in = CMD_READ_SP;
                  end else begin
                     phase_in = PH_RD_LO;
                     shift_in = 8'd0;
                  end
               end
            end
         end
         PH_CONV: begin
            tick_in = tick_inc[19:0];
            if (tick_inc >= {1'b0, cfg.conv_wait}) begin
               phase_in = PH_R2_LOW;
               tick_in  = 20'd0;
            end
         end
         PH_RD_LO, PH_RD_HI: begin
            drive = (tick_ff < {12'd0, cfg.short_slot});
            if (tick_ff >= {11'd0, cfg.short_slot, 1'b0}) begin
               shift_in = shift_rd;
               bit_in   = bit_next;
               tick_in  = 20'd0;
               if (bit_next == 3'd0) begin
                  if (phase_ff == PH_RD_LO) begin
                     low_in   = shift_rd;
                     phase_in = PH_RD_HI;
                     shift_in = 8'd0;
                  end else begin
                     high_in   = shift_rd;
                     result_in = raw_to_centi({shift_rd, low_ff});
                     done      = 1'b1;
                     phase_in  = PH_IDLE;
                  end
               end
            end else begin
               tick_in = tick_inc[19:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = 20'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= 20'd0;
         shift_ff  <= 8'd0;
         bit_ff    <= 3'd0;
         low_ff    <= 8'd0;
         high_ff   <= 8'd0;
         miss_ff   <= 1'b0;
         result_ff <= 18'd0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         shift_ff  <= shift_in;
         bit_ff    <= bit_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         miss_ff   <= miss_in;
         result_ff <= result_in;
      end
   end

   assign result.drive_low     = drive;
   assign result.busy_res      = (phase_ff != PH_IDLE);
   assign result.done_res      = done;
   assign result.no_presence   = miss_in;
   assign result.negative      = high_in[7];
   assign result.centi_degrees = result_in;

endmodule

// ===== design/onewire_thermometer_master.sv =====
// onewire_thermometer_master: top level with the stream ports, register file,
// input and result registers. Depends on owtm_pkg and owtm_seq.
//
// Single-wire bus master for a temperature sensor. Each req word is one
// microsecond tick carrying a start request and the sampled bus level; each
// req word gives exactly one rsp word with the bus drive for that tick, busy,
// done, the presence-missing flag and the last reading as sign plus magnitude
// in hundredths of a degree. A start seen while idle runs reset/presence,
// skip-rom, convert, conversion wait, reset/presence, skip-rom, read-scratchpad
// and a two-byte read, LSB first. One word is taken per clock cycle as long as
// rsp_tready stays high: a word is held in the input register, and the sequencer
// steps once as it moves into the result register that drives rsp. Timing
// registers must be written through the csr port only while no word is in
// flight; the block itself does not enforce this.
module onewire_thermometer_master
   import owtm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] start_req, [1] line_level, [7:2] zero
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                    // [3] no_presence, [4] negative,
                                    // [22:5] centi_degrees, [23] zero
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [19:0] csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       in_start_ff;
   logic       in_line_ff;
   logic       out_valid_ff;
   result_type out_data_ff;
   result_type step_result;
   logic       advance;

   // timing registers, masked to their widths, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low  <= 12'd600;
         cfg_ff.pres_wait  <= 8'd55;
         cfg_ff.pres_tmo   <= 8'd240;
         cfg_ff.long_slot  <= 8'd90;
         cfg_ff.short_slot <= 8'd10;
         cfg_ff.conv_wait  <= 20'd1000;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_RESET_LOW:  cfg_ff.reset_low  <= csr_wdata[11:0];
            REG_PRES_WAIT:  cfg_ff.pres_wait  <= csr_wdata[7:0];
            REG_PRES_TMO:   cfg_ff.pres_tmo   <= csr_wdata[7:0];
            REG_LONG_SLOT:  cfg_ff.long_slot  <= csr_wdata[7:0];
            REG_SHORT_SLOT: cfg_ff.short_slot <= csr_wdata[7:0];
            REG_CONV_WAIT:  cfg_ff.conv_wait  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a word moves on when the result register is empty or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_start_ff <= req_tdata[0];
         in_line_ff  <= req_tdata[1];
      end
   end

   // sequencer steps exactly once per word
   owtm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .start_req  (in_start_ff),
      .line_level (in_line_ff),
      .cfg        (cfg_ff),
      .result     (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

endmodule
